@@ rtl/aes128_pkg.sv @@
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int RoundIdxW = 4;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } cfg_idx_t;

    // Per-stage control handed down the cell chain
    typedef struct packed {
        logic valid;
    } stage_ctl_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t rcon(input logic [RoundIdxW-1:0] rnd);
        byte_t r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key from the previous one (bit 127 = key byte 0 msb)
    function automatic block_t next_round_key(input block_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes and ShiftRows; byte k at bits [127-8k -: 8]
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic block_t mix_cols(input block_t s);
        block_t t;
        byte_t a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

@@ rtl/aes128_if.sv @@
interface aes128_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

interface aes128_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] index;
    logic [63:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/aes128_block_encrypt_top.sv @@
// AES-128 encryption, one round cell per round in a ten-cell chain.
// Channels: in (sink) carries a plaintext beat as data_high/data_low,
// out (source) carries the ciphertext beat, cfg (sink) writes the key:
// index 0 is key_high, index 1 is key_low, other indexes are ignored.
// cfg is always ready; write the key only while the block is empty.
// Path: one entry stage for the initial AddRoundKey plus ten round cells;
// the last cell's registers feed the output.
// Throughput: one block per cycle unless the chain holds; each round cell takes
// a new block whenever the chain advances and derives its round key alongside, so no key schedule is stored.
// Stall: the whole chain holds when the output is valid and not taken;
// in.ready is low for exactly those cycles. Otherwise every stage advances
// together, so empty slots travel down the chain and are not closed up.
// Reset: key returns to all zeros, all stages empty.
module aes128_block_encrypt_top (
    input  logic          clk,
    input  logic          rst_n,
    aes128_blk_if.sink    in,
    aes128_blk_if.source  out,
    aes128_cfg_if.sink    cfg
);

    localparam int NR = aes128_pkg::NumRounds;

    logic [63:0]            key_high_reg, key_low_reg;
    aes128_pkg::stage_ctl_t ctl0_reg;
    aes128_pkg::block_t     st0_reg, key0_reg;
    aes128_pkg::stage_ctl_t ctl [NR+1];
    aes128_pkg::block_t     st  [NR+1];
    aes128_pkg::block_t     rk  [NR+1];
    logic                   advance;

    // Key registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == 64'(aes128_pkg::CFG_KEY_HIGH))
                key_high_reg <= cfg.wdata;
            else if (cfg.index == 64'(aes128_pkg::CFG_KEY_LOW))
                key_low_reg <= cfg.wdata;
        end
    end

    // Chain moves unless the output beat waits
    assign advance  = !ctl[NR].valid || out.ready;
    assign in.ready = advance;

    // Entry stage: initial AddRoundKey
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (advance)
            ctl0_reg.valid <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st0_reg  <= {in.data_high, in.data_low} ^ {key_high_reg, key_low_reg};
            key0_reg <= {key_high_reg, key_low_reg};
        end
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;
    assign rk[0]  = key0_reg;

    for (genvar i = 0; i < NR; i++)
    begin : g_round
        aes128_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .rnd       (4'(i + 1)),
            .last      (i == NR - 1),
            .ctl_in    (ctl[i]),
            .state_in  (st[i]),
            .key_in    (rk[i]),
            .ctl_out   (ctl[i+1]),
            .state_out (st[i+1]),
            .key_out   (rk[i+1])
        );
    end

    assign out.valid     = ctl[NR].valid;
    assign out.data_high = st[NR][127:64];
    assign out.data_low  = st[NR][63:0];

    // A waiting output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.data_high))
        else $error("output beat changed under stall");

    // Input only taken when chain advances
    a_in_adv: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready == (!out.valid || out.ready))
        else $error("input ready mismatch");

    // Accepted beat enters the entry stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in.valid && in.ready |=> ctl0_reg.valid)
        else $error("accepted beat lost at entry");

endmodule

@@ rtl/aes128_round_cell.sv @@
// One round of the chain: state and round key advance together whenever the chain advances
module aes128_round_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [3:0]               rnd,
    input  logic                     last,
    input  aes128_pkg::stage_ctl_t   ctl_in,
    input  aes128_pkg::block_t       state_in,
    input  aes128_pkg::block_t       key_in,
    output aes128_pkg::stage_ctl_t   ctl_out,
    output aes128_pkg::block_t       state_out,
    output aes128_pkg::block_t       key_out
);

    aes128_pkg::stage_ctl_t ctl_reg;
    aes128_pkg::block_t     state_reg, state_next;
    aes128_pkg::block_t     key_reg, key_next;
    aes128_pkg::block_t     ss;

    // Compute round key and round function
    always_comb
    begin
        key_next   = aes128_pkg::next_round_key(key_in, aes128_pkg::rcon(rnd));
        ss         = aes128_pkg::sub_shift(state_in);
        state_next = (last ? ss : aes128_pkg::mix_cols(ss)) ^ key_next;
    end

    // Hold valid under stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    logic clk;
    logic rst_n;
    bit   failed;

    aes128_blk_if in_ch ();
    aes128_blk_if out_ch ();
    aes128_cfg_if cfg_ch ();

    aes128_block_encrypt_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source),
        .cfg   (cfg_ch.sink)
    );

    typedef logic [7:0] octet_t;

    // Standard S-box, held as a table of its own
    octet_t sub_tab [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic octet_t gf_double(octet_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Ciphertext of one block under a 128-bit key; bytes held as array index 0..15
    function automatic logic [127:0] aes_encrypt(logic [127:0] key, logic [127:0] pt);
        logic [31:0] rk [44];
        logic [31:0] t;
        octet_t st [16];
        octet_t nx [16];
        octet_t a0, a1, a2, a3, al;
        octet_t rc;
        logic [127:0] res;
        for (int i = 0; i < 4; i++)
            rk[i] = key[127 - 32 * i -: 32];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = rk[i - 1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sub_tab[t[31:24]] ^ rc, sub_tab[t[23:16]], sub_tab[t[15:8]],
                     sub_tab[t[7:0]]};
                rc = gf_double(rc);
            end
            rk[i] = rk[i - 4] ^ t;
        end
        for (int k = 0; k < 16; k++)
            st[k] = pt[127 - 8 * k -: 8] ^ rk[k / 4][31 - 8 * (k % 4) -: 8];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    nx[r + 4 * c] = sub_tab[st[r + 4 * ((c + r) % 4)]];
            if (rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = nx[4 * c]; a1 = nx[4 * c + 1];
                    a2 = nx[4 * c + 2]; a3 = nx[4 * c + 3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    nx[4 * c]     = a0 ^ al ^ gf_double(a0 ^ a1);
                    nx[4 * c + 1] = a1 ^ al ^ gf_double(a1 ^ a2);
                    nx[4 * c + 2] = a2 ^ al ^ gf_double(a2 ^ a3);
                    nx[4 * c + 3] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            end
            for (int k = 0; k < 16; k++)
                st[k] = nx[k] ^ rk[4 * rnd + k / 4][31 - 8 * (k % 4) -: 8];
        end
        for (int k = 0; k < 16; k++)
            res[127 - 8 * k -: 8] = st[k];
        return res;
    endfunction

    // Expected ciphertexts in order of acceptance, under the key in force
    class cipher_board;
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        logic [127:0] pending [$];
        int           errors;

        function void note_plain(logic [63:0] ph, logic [63:0] pl);
            pending.insert(pending.size(), aes_encrypt({key_hi, key_lo}, {ph, pl}));
        endfunction

        function void check_cipher(logic [63:0] ch, logic [63:0] cl);
            logic [127:0] exp_ct;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected ciphertext %h_%h", $realtime, ch, cl);
                errors++;
                return;
            end
            exp_ct = pending.pop_front();
            if (ch !== exp_ct[127:64])
            begin
                $display("%0t: cipher_high expected %h actual %h", $realtime,
                         exp_ct[127:64], ch);
                errors++;
            end
            if (cl !== exp_ct[63:0])
            begin
                $display("%0t: cipher_low expected %h actual %h", $realtime,
                         exp_ct[63:0], cl);
                errors++;
            end
        endfunction
    endclass

    cipher_board board;
    bit          sink_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Write one key register; the key takes effect for later blocks
    task automatic write_reg(aes128_pkg::cfg_idx_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= 64'(idx);
        cfg_ch.wdata <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == aes128_pkg::CFG_KEY_HIGH) board.key_hi = val;
        else board.key_lo = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Out of range index: must be ignored
    task automatic write_bad_index();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= 64'd2 + 64'($urandom_range(0, 1000));
        cfg_ch.wdata <= rand64();
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Send one plaintext beat, after a random gap unless burst is set
    task automatic send_plain(logic [63:0] ph, logic [63:0] pl, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_high <= ph;
        in_ch.data_low  <= pl;
        do @(posedge clk); while (!in_ch.ready);
        board.note_plain(ph, pl);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // Drain before touching the key
    task automatic wait_empty();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    // Output side: random ready stalls, check every accepted beat
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = sink_enable ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 7) == 0) stall = 0;
            out_ch.ready <= (stall == 0);
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                board.check_cipher(out_ch.data_high, out_ch.data_low);
        end
    end

    initial
    begin
        logic [63:0] ph, pl;
        bit burst;
        board = new();
        board.key_hi = '0;
        board.key_lo = '0;
        sink_enable = 1'b1;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_high = '0;
        in_ch.data_low = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero key before any write, extremes of the data
        send_plain('0, '0, 0);
        send_plain('1, '1, 0);
        send_plain(64'h8000000000000000, 64'h1, 0);
        end_burst();
        wait_empty();

        // Published vector, then an ignored write must not disturb the key
        write_reg(aes128_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
        write_reg(aes128_pkg::CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        write_bad_index();
        send_plain(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_plain('1, '0, 1);
        send_plain('0, '1, 1);
        end_burst();
        wait_empty();

        // All-ones key
        write_reg(aes128_pkg::CFG_KEY_HIGH, '1);
        write_reg(aes128_pkg::CFG_KEY_LOW, '1);
        send_plain('0, '0, 0);
        send_plain('1, '1, 0);
        end_burst();
        wait_empty();

        // Random phases, most under new key bits; some phases at full rate
        for (int ph_i = 0; ph_i < 20; ph_i++)
        begin
            case (ph_i % 4)
                0: write_reg(aes128_pkg::CFG_KEY_HIGH, rand64());
                1: write_reg(aes128_pkg::CFG_KEY_LOW, rand64());
                2:
                begin
                    write_reg(aes128_pkg::CFG_KEY_HIGH, rand64());
                    write_reg(aes128_pkg::CFG_KEY_LOW, rand64());
                end
                default: write_bad_index();
            endcase
            burst = (ph_i % 5 == 3);
            sink_enable = (ph_i % 5 != 4);
            for (int n = 0; n < 100; n++)
            begin
                ph = rand64();
                pl = rand64();
                send_plain(ph, pl, burst);
            end
            end_burst();
            wait_empty();
        end
        sink_enable = 1'b1;

        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
